### rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, codes and word layouts shared by the ray / sphere intersection.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int RadWidth   = CoordWidth - 1;

  // D = O - P
  localparam int DiffWidth  = CoordWidth + 1;
  // A, B, D.D
  localparam int DotWidth   = 2 * DiffWidth + 2;
  // E = B*B - A*C
  localparam int DiscWidth  = 2 * DotWidth + 2;
  localparam int SqrtWidth  = DiscWidth / 2;
  // numerator -B - s, scaled by 2^FracBits
  localparam int NumWidth   = DotWidth + 2 + FracBits;

  // side payload through sqrt: b, a, a_zero, e_neg
  localparam int SqrtSideWidth = 2 * DotWidth + 2;
  // side payload through divider: a_zero, e_neg, tangent, negative
  localparam int DivSideWidth  = 4;

  localparam int InDataWidth  = 6 * CoordWidth;
  localparam int OutDataWidth = ((2 + CoordWidth + 7) / 8) * 8;
  localparam int CfgIdxWidth  = 2;

  typedef enum logic [1:0] {
    HIT_NEAR = 2'd0,
    HIT_TANGENT = 2'd1,
    HIT_MISS = 2'd2,
    HIT_ZERO_DIR = 2'd3
  } hit_status_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_CENTRE_X = 2'd0,
    CFG_CENTRE_Y = 2'd1,
    CFG_CENTRE_Z = 2'd2,
    CFG_RADIUS = 2'd3
  } cfg_idx_t;

endpackage

### rtl/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined restoring square root, one result bit per stage, with a side
// payload that travels in step with the operand.
// ----------------------------------------------------------------------------
module rsi_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [rsi_pkg::DiscWidth-1:0]     in_rad,
  input  logic [rsi_pkg::SqrtSideWidth-1:0] in_side,
  output logic                              out_valid,
  output logic [rsi_pkg::SqrtWidth-1:0]     out_root,
  output logic [rsi_pkg::SqrtSideWidth-1:0] out_side
);

  localparam int Width     = rsi_pkg::DiscWidth;
  localparam int SideWidth = rsi_pkg::SqrtSideWidth;
  localparam int Steps     = rsi_pkg::SqrtWidth;

  logic                 vld_r  [Steps+1];
  logic [Width-1:0]     rem_r  [Steps+1];
  logic [Width-1:0]     rad_r  [Steps+1];
  logic [Steps-1:0]     root_r [Steps+1];
  logic [SideWidth-1:0] side_r [Steps+1];

  assign vld_r[0]  = in_valid;
  assign rem_r[0]  = '0;
  assign rad_r[0]  = in_rad;
  assign root_r[0] = '0;
  assign side_r[0] = in_side;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [Width-1:0] rem_sh;
    logic [Width-1:0] trial;
    logic             fit;
    assign rem_sh = {rem_r[k][Width-3:0], rad_r[k][Width-1 -: 2]};
    assign trial  = Width'({root_r[k][Steps-1:0], 2'b01});
    assign fit    = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= fit ? rem_sh - trial : rem_sh;
        rad_r[k+1]  <= {rad_r[k][Width-3:0], 2'b00};
        root_r[k+1] <= {root_r[k][Steps-2:0], fit};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[Steps];
  assign out_root  = root_r[Steps];
  assign out_side  = side_r[Steps];

endmodule

### rtl/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined restoring unsigned divider, one quotient bit per stage, carrying
// a side payload and the inexact flag at the end.
// ----------------------------------------------------------------------------
module rsi_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [rsi_pkg::NumWidth-1:0]     in_num,
  input  logic [rsi_pkg::DotWidth-1:0]     in_den,
  input  logic [rsi_pkg::DivSideWidth-1:0] in_side,
  output logic                             out_valid,
  output logic [rsi_pkg::NumWidth-1:0]     out_quot,
  output logic                             out_inexact,
  output logic [rsi_pkg::DivSideWidth-1:0] out_side
);

  localparam int NumW      = rsi_pkg::NumWidth;
  localparam int DenW      = rsi_pkg::DotWidth;
  localparam int SideWidth = rsi_pkg::DivSideWidth;

  logic                 vld_r  [NumW+1];
  logic [DenW:0]        rem_r  [NumW+1];
  logic [NumW-1:0]      num_r  [NumW+1];
  logic [NumW-1:0]      quo_r  [NumW+1];
  logic [DenW-1:0]      den_r  [NumW+1];
  logic [SideWidth-1:0] side_r [NumW+1];

  assign vld_r[0]  = in_valid;
  assign rem_r[0]  = '0;
  assign num_r[0]  = in_num;
  assign quo_r[0]  = '0;
  assign den_r[0]  = in_den;
  assign side_r[0] = in_side;

  for (genvar k = 0; k < NumW; k++) begin : g_step
    logic [DenW+1:0] rem_sh;
    logic [DenW+1:0] diff;
    assign rem_sh = {rem_r[k], num_r[k][NumW-1]};
    assign diff   = rem_sh - {2'b00, den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= diff[DenW+1] ? rem_sh[DenW:0] : diff[DenW:0];
        num_r[k+1]  <= {num_r[k][NumW-2:0], 1'b0};
        quo_r[k+1]  <= {quo_r[k][NumW-2:0], ~diff[DenW+1]};
        den_r[k+1]  <= den_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid   = vld_r[NumW];
  assign out_quot    = quo_r[NumW];
  assign out_inexact = |rem_r[NumW];
  assign out_side    = side_r[NumW];

endmodule

### rtl/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray / sphere hit test in signed Q16.16: status and nearer ray parameter.
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel: one ray per word, origin x/y/z then direction x/y/z.
//   out_ channel: one word per ray, hit status and distance t.
//   cfg_ port: write centre x/y/z (index 0..2) and radius (index 3) while
//   the pipeline is empty; writes beyond index 3 are ignored.
// Throughput: one ray per cycle while out_ is not stalled. Pipeline depth:
//   6 arithmetic stages, one stage per bit of the square root (SqrtWidth),
//   one numerator stage, one stage per quotient bit (NumWidth) and two
//   rounding/saturation stages, 164 register stages at Q16.16.
// Reset clears all valid bits and sets centre 0, radius 1.0.
// A stall on out_ freezes the whole pipeline; in_tready follows out_tready
// or an empty output register, so no word is lost or repeated.
// ----------------------------------------------------------------------------
module ray_sphere_intersect (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [rsi_pkg::InDataWidth-1:0]         in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // hit_status, distance, zero fill
  output logic [rsi_pkg::OutDataWidth-1:0]        out_tdata,
  input  logic                                    cfg_we,
  input  logic [rsi_pkg::CfgIdxWidth-1:0]         cfg_index,
  input  logic [rsi_pkg::CoordWidth-1:0]          cfg_data
);

  localparam int CW  = rsi_pkg::CoordWidth;
  localparam int FB  = rsi_pkg::FracBits;
  localparam int DW  = rsi_pkg::DiffWidth;
  localparam int TW  = rsi_pkg::DotWidth;
  localparam int HW  = TW / 2;
  localparam int EW  = rsi_pkg::DiscWidth;
  localparam int SW  = rsi_pkg::SqrtWidth;
  localparam int NW  = rsi_pkg::NumWidth;
  localparam int PW  = 2 * DW;
  // side payload through sqrt: b, a, a_zero, e_neg
  localparam int SQS = rsi_pkg::SqrtSideWidth;
  // side payload through divider: a_zero, e_neg, tangent, negative
  localparam int DVS = rsi_pkg::DivSideWidth;

  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic [rsi_pkg::RadWidth-1:0] rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= rsi_pkg::RadWidth'(1 << FB);
    end else if (cfg_we) begin
      unique case (rsi_pkg::cfg_idx_t'(cfg_index))
        rsi_pkg::CFG_CENTRE_X: cx_r  <= cfg_data;
        rsi_pkg::CFG_CENTRE_Y: cy_r  <= cfg_data;
        rsi_pkg::CFG_CENTRE_Z: cz_r  <= cfg_data;
        rsi_pkg::CFG_RADIUS:   rad_r <= cfg_data[rsi_pkg::RadWidth-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_r;
  assign en        = out_tready || !out_vld_r;
  assign in_tready = en;

  // stage 1: differences
  logic s1_v_r;
  logic signed [DW-1:0] s1_v_x_r, s1_v_y_r, s1_v_z_r, s1_d_x_r, s1_d_y_r, s1_d_z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_v_x_r <= DW'($signed(in_tdata[3*CW +: CW]));
      s1_v_y_r <= DW'($signed(in_tdata[4*CW +: CW]));
      s1_v_z_r <= DW'($signed(in_tdata[5*CW +: CW]));
      s1_d_x_r <= DW'($signed(in_tdata[0*CW +: CW])) - DW'(cx_r);
      s1_d_y_r <= DW'($signed(in_tdata[1*CW +: CW])) - DW'(cy_r);
      s1_d_z_r <= DW'($signed(in_tdata[2*CW +: CW])) - DW'(cz_r);
    end
  end

  // stage 2: products
  logic s2_v_r;
  logic signed [PW-1:0] s2_aa_r [3];
  logic signed [PW-1:0] s2_bb_r [3];
  logic signed [PW-1:0] s2_cc_r [3];
  logic        [PW-1:0] s2_rr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_aa_r[0] <= s1_v_x_r * s1_v_x_r;
      s2_aa_r[1] <= s1_v_y_r * s1_v_y_r;
      s2_aa_r[2] <= s1_v_z_r * s1_v_z_r;
      s2_bb_r[0] <= s1_v_x_r * s1_d_x_r;
      s2_bb_r[1] <= s1_v_y_r * s1_d_y_r;
      s2_bb_r[2] <= s1_v_z_r * s1_d_z_r;
      s2_cc_r[0] <= s1_d_x_r * s1_d_x_r;
      s2_cc_r[1] <= s1_d_y_r * s1_d_y_r;
      s2_cc_r[2] <= s1_d_z_r * s1_d_z_r;
      s2_rr_r    <= PW'(rad_r) * PW'(rad_r);
    end
  end

  // stage 3: dot products A, B, C
  logic s3_v_r;
  logic signed [TW-1:0] s3_a_r, s3_b_r, s3_c_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_a_r <= TW'(s2_aa_r[0]) + TW'(s2_aa_r[1]) + TW'(s2_aa_r[2]);
      s3_b_r <= TW'(s2_bb_r[0]) + TW'(s2_bb_r[1]) + TW'(s2_bb_r[2]);
      s3_c_r <= TW'(s2_cc_r[0]) + TW'(s2_cc_r[1]) + TW'(s2_cc_r[2])
                - TW'($signed({1'b0, s2_rr_r}));
    end
  end

  // stage 4a: partial products of B*B and A*C on half-width pieces
  logic s4p_v_r;
  logic signed [2*HW-1:0] s4p_bhh_r, s4p_ahh_r;
  logic signed [2*HW:0]   s4p_bhl_r, s4p_ahl_r, s4p_alh_r;
  logic        [2*HW-1:0] s4p_bll_r, s4p_all_r;
  logic signed [TW-1:0]   s4p_a_r, s4p_b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4p_v_r <= 1'b0;
    else if (en) s4p_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4p_bhh_r <= $signed(s3_b_r[TW-1:HW]) * $signed(s3_b_r[TW-1:HW]);
      s4p_bhl_r <= $signed(s3_b_r[TW-1:HW]) * $signed({1'b0, s3_b_r[HW-1:0]});
      s4p_bll_r <= s3_b_r[HW-1:0] * s3_b_r[HW-1:0];
      s4p_ahh_r <= $signed(s3_a_r[TW-1:HW]) * $signed(s3_c_r[TW-1:HW]);
      s4p_ahl_r <= $signed(s3_a_r[TW-1:HW]) * $signed({1'b0, s3_c_r[HW-1:0]});
      s4p_alh_r <= $signed(s3_c_r[TW-1:HW]) * $signed({1'b0, s3_a_r[HW-1:0]});
      s4p_all_r <= s3_a_r[HW-1:0] * s3_c_r[HW-1:0];
      s4p_a_r   <= s3_a_r;
      s4p_b_r   <= s3_b_r;
    end
  end

  // stage 4b: B*B and A*C
  logic s4_v_r;
  logic signed [EW-1:0] s4_bb_r, s4_ac_r;
  logic signed [TW-1:0] s4_a_r, s4_b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= s4p_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_bb_r <= (EW'(s4p_bhh_r) <<< TW) + (EW'(s4p_bhl_r) <<< (HW + 1))
                 + EW'(s4p_bll_r);
      s4_ac_r <= (EW'(s4p_ahh_r) <<< TW) + ((EW'(s4p_ahl_r) + EW'(s4p_alh_r)) <<< HW)
                 + EW'(s4p_all_r);
      s4_a_r  <= s4p_a_r;
      s4_b_r  <= s4p_b_r;
    end
  end

  // stage 5: discriminant
  logic s5_v_r;
  logic signed [EW-1:0] s5_e_r;
  logic signed [TW-1:0] s5_a_r, s5_b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_e_r <= s4_bb_r - s4_ac_r;
      s5_a_r <= s4_a_r;
      s5_b_r <= s4_b_r;
    end
  end

  logic [SQS-1:0] sq_side_in, sq_side_out;
  logic           sq_v;
  logic [SW-1:0]  sq_root;
  logic [EW-1:0]  sq_rad;
  assign sq_rad = s5_e_r[EW-1] ? '0 : s5_e_r;
  assign sq_side_in = {s5_b_r, s5_a_r, (s5_a_r == '0), s5_e_r[EW-1]};

  rsi_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (s5_v_r),
    .in_rad   (sq_rad),
    .in_side  (sq_side_in),
    .out_valid(sq_v),
    .out_root (sq_root),
    .out_side (sq_side_out)
  );

  // numerator stage
  logic signed [TW-1:0] sq_b, sq_a;
  assign sq_b = sq_side_out[SQS-1 -: TW];
  assign sq_a = sq_side_out[2 +: TW];

  logic n_v_r;
  logic [NW-1:0] n_mag_r;
  logic [TW-1:0] n_den_r;
  logic [DVS-1:0] n_side_r;
  logic signed [NW-1:0] n_raw;
  assign n_raw = (-NW'(sq_b) - NW'($signed({1'b0, sq_root[TW:0]}))) <<< FB;
  always_ff @(posedge clk) begin
    if (!rst_n) n_v_r <= 1'b0;
    else if (en) n_v_r <= sq_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n_mag_r  <= n_raw[NW-1] ? -n_raw : n_raw;
      n_den_r  <= (sq_a == '0) ? TW'(1) : sq_a;
      n_side_r <= {sq_side_out[1], sq_side_out[0], (sq_root == '0), n_raw[NW-1]};
    end
  end

  logic dv_v, dv_inexact;
  logic [NW-1:0] dv_q;
  logic [DVS-1:0] dv_side;

  rsi_div u_div (
    .clk, .rst_n, .en,
    .in_valid   (n_v_r),
    .in_num     (n_mag_r),
    .in_den     (n_den_r),
    .in_side    (n_side_r),
    .out_valid  (dv_v),
    .out_quot   (dv_q),
    .out_inexact(dv_inexact),
    .out_side   (dv_side)
  );

  // sign and floor
  logic r_v_r;
  logic signed [NW:0] r_q_r;
  logic [DVS-1:0] r_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) r_v_r <= 1'b0;
    else if (en) r_v_r <= dv_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r_q_r <= dv_side[0] ? -$signed({1'b0, dv_q}) - (NW+1)'(dv_inexact)
                          : $signed({1'b0, dv_q});
      r_side_r <= dv_side;
    end
  end

  // saturate and select status
  localparam logic signed [NW:0] QHi = (NW+1)'((64'd1 << (CW - 1)) - 1);
  localparam logic signed [NW:0] QLo = -QHi - 1;
  logic [CW-1:0] minus_one;
  logic [CW-1:0] sat_q;
  rsi_pkg::hit_status_t st;
  logic [CW-1:0] distance;
  assign minus_one = ~CW'((1 << FB) - 1);
  assign sat_q = (r_q_r > QHi) ? QHi[CW-1:0] :
                 (r_q_r < QLo) ? QLo[CW-1:0] : r_q_r[CW-1:0];

  always_comb begin
    priority if (r_side_r[3]) begin
      st = rsi_pkg::HIT_ZERO_DIR; distance = minus_one;
    end else if (r_side_r[2]) begin
      st = rsi_pkg::HIT_MISS; distance = minus_one;
    end else if (r_side_r[1]) begin
      st = rsi_pkg::HIT_TANGENT; distance = sat_q;
    end else begin
      st = rsi_pkg::HIT_NEAR; distance = sat_q;
    end
  end

  logic [rsi_pkg::OutDataWidth-1:0] out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= r_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) out_data_r <= rsi_pkg::OutDataWidth'({distance, st});
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
  a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == rsi_pkg::HIT_MISS ||
                   out_tdata[1:0] == rsi_pkg::HIT_ZERO_DIR)
    |-> out_tdata[2 +: CW] == minus_one)
    else $error("miss without -1.0 distance");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Ray / sphere intersection: directed and randomised stream test against an exact
// wide-integer predictor of status and floored, saturated distance, with
// several sphere settings and random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [31:0] dz, dy, dx, oz, oy, ox;
  } ray_t;

  typedef struct {
    rsi_pkg::hit_status_t status;
    logic [31:0] distance;
  } hit_t;

  class hit_scoreboard;
    logic [31:0] cx, cy, cz;
    logic [30:0] rad;
    hit_t        hits_due[$];
    int          fails;

    function new();
      cx = 0; cy = 0; cz = 0; rad = 31'd65536; fails = 0;
    endfunction

    function void set_reg(rsi_pkg::cfg_idx_t idx, logic [31:0] v);
      unique case (idx)
        rsi_pkg::CFG_CENTRE_X: cx = v;
        rsi_pkg::CFG_CENTRE_Y: cy = v;
        rsi_pkg::CFG_CENTRE_Z: cz = v;
        rsi_pkg::CFG_RADIUS:   rad = v[30:0];
      endcase
    endfunction

    function wide_t floor_sqrt(wide_t e);
      wide_t s, t;
      s = 0;
      for (int i = 127; i >= 0; i--) begin
        t = s | (wide_t'(1) <<< i);
        if (t * t <= e) s = t;
      end
      return s;
    endfunction

    function void note_ray(ray_t r);
      wide_t vx, vy, vz, dx, dy, dz, rr, a, b, c, e, num, q;
      hit_t  h;
      vx = $signed(r.dx); vy = $signed(r.dy); vz = $signed(r.dz);
      dx = $signed(r.ox); dx = dx - $signed(cx);
      dy = $signed(r.oy); dy = dy - $signed(cy);
      dz = $signed(r.oz); dz = dz - $signed(cz);
      rr = {225'b0, rad};
      a = vx * vx + vy * vy + vz * vz;
      b = vx * dx + vy * dy + vz * dz;
      c = dx * dx + dy * dy + dz * dz - rr * rr;
      e = b * b - a * c;
      h.distance = 32'hFFFF_0000;
      if (a == 0) h.status = rsi_pkg::HIT_ZERO_DIR;
      else if (e < 0) h.status = rsi_pkg::HIT_MISS;
      else begin
        h.status = (e == 0) ? rsi_pkg::HIT_TANGENT : rsi_pkg::HIT_NEAR;
        num = (-b - floor_sqrt(e)) <<< rsi_pkg::FracBits;
        q = num / a;
        if (num < 0 && q * a != num) q = q - 1;
        if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
        if (q < -64'sh8000_0000) q = -64'sh8000_0000;
        h.distance = q[31:0];
      end
      hits_due = {hits_due, h};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s got %h want %h", $realtime, what, got, want);
      fails++;
    endtask

    task check(logic [rsi_pkg::OutDataWidth-1:0] w);
      hit_t h;
      if (hits_due.size() == 0) begin
        report("unexpected word", w[33:2], 32'd0);
        return;
      end
      h = hits_due.pop_front();
      if (w[1:0] != h.status) report("hit_status", 32'(w[1:0]), 32'(h.status));
      if (w[33:2] != h.distance) report("distance", w[33:2], h.distance);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready, out_tvalid, out_tready = 0;
  logic [rsi_pkg::InDataWidth-1:0] in_tdata = '0;
  logic [rsi_pkg::OutDataWidth-1:0] out_tdata;
  logic cfg_we = 0;
  logic [rsi_pkg::CfgIdxWidth-1:0] cfg_index = '0;
  logic [rsi_pkg::CoordWidth-1:0] cfg_data = '0;
  hit_scoreboard sb = new();
  bit in_busy = 1, out_busy = 1;
  int stall_left = 0;

  ray_sphere_intersect u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check(out_tdata);
      stall_left = out_busy ? $urandom_range(0, 3) : 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  task send_ray(ray_t r);
    int gap;
    gap = in_busy ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= r;
    do @(posedge clk); while (!in_tready);
    sb.note_ray(r);
  endtask

  task drain();
    while (sb.hits_due.size() != 0) @(posedge clk);
  endtask

  task set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] r);
    logic [31:0] v[4];
    v = '{x, y, z, r};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= rsi_pkg::cfg_idx_t'(i);
      cfg_data <= v[i];
      sb.set_reg(rsi_pkg::cfg_idx_t'(i), v[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function logic [31:0] fx(int n);
    return n <<< 16;
  endfunction

  function logic [31:0] near_coord();
    return $urandom_range(0, 3) == 0 ? $urandom() : $signed($urandom_range(0, 'h40_0000)) - 'h20_0000;
  endfunction

  // aim at the sphere, with some jitter so both hits and misses occur
  function ray_t aimed_ray();
    ray_t r;
    logic [31:0] o[3], c[3], jit;
    c = '{sb.cx, sb.cy, sb.cz};
    for (int k = 0; k < 3; k++) begin
      o[k] = $urandom_range(0, 4) == 0 ? $urandom() : c[k] + near_coord();
      jit = $urandom_range(0, 1) ? {{2{sb.rad[30]}}, sb.rad[30:1]} : {1'b0, sb.rad};
      jit = $urandom_range(0, 1) ? jit : -jit;
      r[96 + 32 * k +: 32] = c[k] - o[k] + ($urandom_range(0, 2) == 0 ? jit : 32'(0));
      r[32 * k +: 32] = o[k];
    end
    if ($urandom_range(0, 9) == 0) r.dx = $urandom();
    return r;
  endfunction

  initial begin
    ray_t r;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_ray('{ox:fx(-5), oy:0, oz:0, dx:0, dy:0, dz:0});
    send_ray('{ox:fx(-5), oy:fx(3), oz:0, dx:fx(1), dy:0, dz:0});
    send_ray('{ox:fx(-5), oy:fx(1), oz:0, dx:fx(1), dy:0, dz:0});
    send_ray('{ox:fx(-5), oy:0, oz:0, dx:fx(2), dy:0, dz:0});
    send_ray('{ox:fx(5), oy:0, oz:0, dx:fx(1), dy:0, dz:0});
    send_ray('{ox:0, oy:0, oz:0, dx:0, dy:fx(-1), dz:0});
    send_ray('{ox:fx(-30000), oy:0, oz:0, dx:1, dy:0, dz:0});
    send_ray('{ox:fx(30000), oy:0, oz:0, dx:1, dy:0, dz:0});
    send_ray('{ox:32'h8000_0000, oy:32'h8000_0000, oz:32'h8000_0000,
               dx:32'h7FFF_FFFF, dy:32'h7FFF_FFFF, dz:32'h7FFF_FFFF});
    send_ray('{ox:32'h7FFF_FFFF, oy:32'h7FFF_FFFF, oz:32'h7FFF_FFFF,
               dx:32'h8000_0000, dy:32'h8000_0000, dz:32'h8000_0000});
    send_ray('{ox:32'hFFFF_FFFF, oy:0, oz:32'h7FFF_FFFF,
               dx:32'h8000_0000, dy:32'hFFFF_FFFF, dz:1});
    send_ray('{ox:0, oy:fx(-3), oz:fx(-4), dx:0, dy:fx(3), dz:fx(4)});
    in_tvalid <= 0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      unique case (ph)
        1: set_sphere(fx(10), fx(-20), fx(3), fx(5));
        2: set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        3: set_sphere(fx(-1), fx(2), 0, 0);
        4: set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        5: set_sphere($urandom(), $urandom(), $urandom(), $urandom());
        default: ;
      endcase
      for (int i = 0; i < 240; i++) begin
        if (i % 60 == 0) begin
          in_busy = $urandom_range(0, 3) != 0;
          out_busy = $urandom_range(0, 3) != 0;
        end
        if ($urandom_range(0, 4) == 0) r = {$urandom(), $urandom(), $urandom(),
                                            $urandom(), $urandom(), $urandom()};
        else r = aimed_ray();
        send_ray(r);
      end
      in_tvalid <= 0;
      drain();
    end

    repeat (400) @(posedge clk);
    if (sb.fails == 0 && sb.hits_due.size() == 0) $display("ray_sphere_intersect: match");
    else $display("ray_sphere_intersect: mismatch");
    $finish;
  end

  initial begin
    #2ms;
    $display("ray_sphere_intersect: mismatch");
    $finish;
  end
endmodule
